// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the frame unmasker RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/wfu_pkg.sv -----
// Types and constants for the frame unmasker.
// No dependencies; used by every module of the block.
package wfu_pkg;

    localparam logic [6:0] LEN_EXTENDED = 7'd126;

    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_EXT_HI  = 4'd2,
        PH_EXT_LO  = 4'd3,
        PH_MASK0   = 4'd4,
        PH_MASK1   = 4'd5,
        PH_MASK2   = 4'd6,
        PH_MASK3   = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_DONE    = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       message_last;
    } out_word_t;

    // Result of one accepted word, handed from the core to the output stage.
    typedef struct packed {
        logic      emit;
        out_word_t word;
    } result_t;

endpackage

// ----- hdl/websocket_frame_unmasker.sv -----
// Payload bytes and end markers are registered: m_ is driven by the output register.
// Throughput: one word per cycle; the output register plus one skid entry hold results
// while m_ready is low, and s_ready drops only when the skid entry is occupied.
// Reset (aresetn low, synchronous) returns the parser to the first header byte and
// empties both output entries. Depends on wfu_pkg, wfu_core and wfu_out_stage.
module websocket_frame_unmasker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wfu_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wfu_pkg::out_word_t m_data
);

    logic             accept;
    wfu_pkg::result_t result;

    assign accept = s_valid & s_ready;

    wfu_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_word (s_data),
        .result  (result)
    );

    wfu_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .result   (result),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- hdl/wfu_core.sv -----
// Frame parser and unmask datapath: phase, length, mask, count and closed registers.
// Depends on wfu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wfu_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  wfu_pkg::in_word_t in_word,
    output wfu_pkg::result_t  result
);

    wfu_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     length_reg, length_next;
    logic [31:0]     mask_reg, mask_next;
    logic [15:0]     count_reg, count_next;
    logic            closed_reg, closed_next;

    logic            step_emit, step_last, step_valid;
    logic [7:0]      step_byte;
    logic [7:0]      mask_byte;
    logic [15:0]     count_inc;

    assign count_inc = count_reg + 16'd1;

    always_comb begin
        unique case (count_reg[1:0])
            2'd0:    mask_byte = mask_reg[31:24];
            2'd1:    mask_byte = mask_reg[23:16];
            2'd2:    mask_byte = mask_reg[15:8];
            default: mask_byte = mask_reg[7:0];
        endcase
    end

    // Next state of the frame walk.
    always_comb begin
        phase_next  = phase_reg;
        length_next = length_reg;
        mask_next   = mask_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        unique case (phase_reg)
            wfu_pkg::PH_HDR0: phase_next = wfu_pkg::PH_HDR1;
            wfu_pkg::PH_HDR1: begin
                if (in_word.data_byte[6:0] == wfu_pkg::LEN_EXTENDED) begin
                    phase_next = wfu_pkg::PH_EXT_HI;
                end else begin
                    length_next = {9'd0, in_word.data_byte[6:0]};
                    phase_next  = wfu_pkg::PH_MASK0;
                end
            end
            wfu_pkg::PH_EXT_HI: begin
                length_next = {in_word.data_byte, 8'd0};
                phase_next  = wfu_pkg::PH_EXT_LO;
            end
            wfu_pkg::PH_EXT_LO: begin
                length_next = {length_reg[15:8], in_word.data_byte};
                phase_next  = wfu_pkg::PH_MASK0;
            end
            wfu_pkg::PH_MASK0, wfu_pkg::PH_MASK1, wfu_pkg::PH_MASK2: begin
                mask_next  = {mask_reg[23:0], in_word.data_byte};
                phase_next = wfu_pkg::phase_t'(phase_reg + 4'd1);
            end
            wfu_pkg::PH_MASK3: begin
                mask_next = {mask_reg[23:0], in_word.data_byte};
                if (length_reg == 16'd0) begin
                    closed_next = 1'b1;
                    phase_next  = wfu_pkg::PH_DONE;
                end else begin
                    phase_next = wfu_pkg::PH_PAYLOAD;
                end
            end
            wfu_pkg::PH_PAYLOAD: begin
                count_next = count_inc;
                if (count_inc == length_reg) begin
                    closed_next = 1'b1;
                    phase_next  = wfu_pkg::PH_DONE;
                end
            end
            wfu_pkg::PH_DONE: phase_next = wfu_pkg::PH_DONE;
            default:          phase_next = wfu_pkg::PH_HDR0;
        endcase
        // Drop all frame state after the buffer's final word.
        if (in_word.buffer_end) begin
            phase_next  = wfu_pkg::PH_HDR0;
            length_next = 16'd0;
            mask_next   = 32'd0;
            count_next  = 16'd0;
            closed_next = 1'b0;
        end
    end

    // Result of the current word.
    always_comb begin
        step_emit  = 1'b0;
        step_last  = 1'b0;
        step_valid = 1'b0;
        step_byte  = 8'd0;
        unique case (phase_reg)
            wfu_pkg::PH_MASK3: begin
                if (length_reg == 16'd0) begin
                    step_emit = 1'b1;
                    step_last = 1'b1;
                end
            end
            wfu_pkg::PH_PAYLOAD: begin
                step_emit  = 1'b1;
                step_valid = 1'b1;
                step_byte  = in_word.data_byte ^ mask_byte;
                step_last  = (count_inc == length_reg);
            end
            default: step_emit = 1'b0;
        endcase
        result.emit              = step_emit
                                 | (in_word.buffer_end & ~closed_reg & ~step_last);
        result.word.payload_byte = step_byte;
        result.word.byte_valid   = step_valid;
        result.word.message_last = step_last | in_word.buffer_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= wfu_pkg::PH_HDR0;
            length_reg <= 16'd0;
            mask_reg   <= 32'd0;
            count_reg  <= 16'd0;
            closed_reg <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            mask_reg   <= mask_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
        end
    end

    `ASSERT_NEXT(a_end_clears, aclk, aresetn, accept && in_word.buffer_end,
        phase_reg == wfu_pkg::PH_HDR0 && !closed_reg && count_reg == 16'd0,
        "frame state not cleared after buffer end")
    `ASSERT_IMPL(a_closed_done, aclk, aresetn, closed_reg,
        phase_reg == wfu_pkg::PH_DONE, "message closed outside done phase")
    `ASSERT_IMPL(a_count_bound, aclk, aresetn, phase_reg == wfu_pkg::PH_PAYLOAD,
        count_reg < length_reg, "payload count reached length while still in payload")

endmodule

// ----- hdl/wfu_out_stage.sv -----
// Output register with a skid entry so the input side keeps flowing under stall.
// Depends on wfu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wfu_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  wfu_pkg::result_t   result,
    output logic               in_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output wfu_pkg::out_word_t m_data
);

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    wfu_pkg::out_word_t out_word_reg, out_word_next;
    wfu_pkg::out_word_t skid_word_reg, skid_word_next;
    logic               push, out_free;

    assign push     = accept & result.emit;
    assign out_free = ~out_valid_reg | m_ready;
    assign in_ready = ~skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_word_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_free) begin
            // Advance the skid word first; a new word cannot arrive while it is held.
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_word_next  = result.word;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_word_next  = result.word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    `ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg,
        "skid word held with empty output register")
    `ASSERT_IMPL(a_no_push_full, aclk, aresetn, skid_valid_reg, !accept,
        "word accepted while skid entry full")

endmodule

// ----- sim/tb_websocket_frame_unmasker.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_unmasker: directed and random frames,
// checked against an in-bench model of the unmasking parser. Depends on wfu_pkg.
module tb_websocket_frame_unmasker;

    typedef logic [7:0] byte_q_t[$];
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC} ready_mode_t;

    localparam int unsigned RANDOM_WORDS = 1100;
    localparam int unsigned HOLDOFF_CYCLES = 150;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    wfu_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    wfu_pkg::out_word_t m_data;

    // Parser model state
    wfu_pkg::phase_t rx_phase;
    logic [15:0]     rx_len;
    logic [31:0]     rx_key;
    logic [15:0]     rx_count;
    logic            rx_closed;

    wfu_pkg::out_word_t expected_words[$];
    int unsigned        words_sent;
    int unsigned        error_count;
    int unsigned        burst_left;
    bit                 gaps_on;
    ready_mode_t        ready_mode;
    bit                 holdoff_req;

    websocket_frame_unmasker DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void clear_parser();
        rx_phase  = wfu_pkg::PH_HDR0;
        rx_len    = '0;
        rx_key    = '0;
        rx_count  = '0;
        rx_closed = 1'b0;
    endfunction

    // Advance the model by one accepted word and queue the result it causes.
    function automatic void unmask_step(input wfu_pkg::in_word_t w);
        wfu_pkg::out_word_t r;
        logic               emit;
        logic [1:0]         idx;
        logic [7:0]         key_byte;
        r    = '0;
        emit = 1'b0;
        case (rx_phase)
            wfu_pkg::PH_HDR0: rx_phase = wfu_pkg::PH_HDR1;
            wfu_pkg::PH_HDR1: begin
                if (w.data_byte[6:0] == wfu_pkg::LEN_EXTENDED) begin
                    rx_phase = wfu_pkg::PH_EXT_HI;
                end else begin
                    rx_len   = {9'd0, w.data_byte[6:0]};
                    rx_phase = wfu_pkg::PH_MASK0;
                end
            end
            wfu_pkg::PH_EXT_HI: begin
                rx_len   = {w.data_byte, 8'h00};
                rx_phase = wfu_pkg::PH_EXT_LO;
            end
            wfu_pkg::PH_EXT_LO: begin
                rx_len   = rx_len | {8'h00, w.data_byte};
                rx_phase = wfu_pkg::PH_MASK0;
            end
            wfu_pkg::PH_MASK0, wfu_pkg::PH_MASK1, wfu_pkg::PH_MASK2: begin
                rx_key   = {rx_key[23:0], w.data_byte};
                rx_phase = wfu_pkg::phase_t'(rx_phase + 4'd1);
            end
            wfu_pkg::PH_MASK3: begin
                rx_key = {rx_key[23:0], w.data_byte};
                if (rx_len == 16'd0) begin
                    emit           = 1'b1;
                    r.message_last = 1'b1;
                    rx_closed      = 1'b1;
                    rx_phase       = wfu_pkg::PH_DONE;
                end else begin
                    rx_phase = wfu_pkg::PH_PAYLOAD;
                end
            end
            wfu_pkg::PH_PAYLOAD: begin
                idx            = rx_count[1:0];
                key_byte       = rx_key[8 * (3 - idx) +: 8];
                r.payload_byte = w.data_byte ^ key_byte;
                r.byte_valid   = 1'b1;
                emit           = 1'b1;
                rx_count       = rx_count + 16'd1;
                if (rx_count == rx_len) begin
                    r.message_last = 1'b1;
                    rx_closed      = 1'b1;
                    rx_phase       = wfu_pkg::PH_DONE;
                end
            end
            default: ;
        endcase
        if (w.buffer_end) begin
            if (!rx_closed) begin
                emit           = 1'b1;
                r.message_last = 1'b1;
            end
            clear_parser();
        end
        if (emit)
            expected_words = {expected_words, r};
    endfunction

    // Offer one word and hold it until accepted; with gaps on, insert a gap between bursts.
    task automatic send_word(input logic [7:0] b, input logic last_byte);
        wfu_pkg::in_word_t w;
        int unsigned gap;
        w.data_byte  = b;
        w.buffer_end = last_byte;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        unmask_step(w);
        words_sent++;
    endtask

    task automatic send_buffer(input byte_q_t bytes);
        foreach (bytes[i])
            send_word(bytes[i], i == bytes.size() - 1);
    endtask

    // Receiver: hold off on request, otherwise stall per the current mode.
    initial begin
        int unsigned hold_left;
        int unsigned cyc;
        hold_left = 0;
        cyc = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                hold_left   = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    RDY_ALWAYS:   m_ready <= 1'b1;
                    RDY_RANDOM:   m_ready <= ($urandom_range(0, 99) >= 35);
                    RDY_PERIODIC: m_ready <= (cyc % 7) > 2;
                    default:      m_ready <= 1'b1;
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        wfu_pkg::out_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result: payload_byte %0h byte_valid %0b message_last %0b",
                       m_data.payload_byte, m_data.byte_valid, m_data.message_last);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (m_data.payload_byte !== exp_w.payload_byte) begin
                    $error("payload_byte: expected %0h, got %0h",
                           exp_w.payload_byte, m_data.payload_byte);
                    error_count++;
                end
                if (m_data.byte_valid !== exp_w.byte_valid) begin
                    $error("byte_valid: expected %0b, got %0b",
                           exp_w.byte_valid, m_data.byte_valid);
                    error_count++;
                end
                if (m_data.message_last !== exp_w.message_last) begin
                    $error("message_last: expected %0b, got %0b",
                           exp_w.message_last, m_data.message_last);
                    error_count++;
                end
            end
        end
    end

    task automatic test_short_buffers();
        byte_q_t q;
        q = '{8'h81};
        send_buffer(q);
        // ends inside the extended length field
        q = '{8'h00, 8'hFE, 8'h00};
        send_buffer(q);
    endtask

    task automatic test_zero_length();
        byte_q_t q;
        // marker on the last mask byte; trailing byte and end are ignored
        q = '{8'h81, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        send_buffer(q);
    endtask

    task automatic test_exact_length();
        byte_q_t q;
        q = '{8'h82, 8'h82, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00, 8'hFF};
        send_buffer(q);
    endtask

    task automatic test_early_end();
        byte_q_t q;
        q = '{8'h81, 8'hFE, 8'h00, 8'h05, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
        send_buffer(q);
    endtask

    task automatic test_output_holdoff();
        byte_q_t q;
        gaps_on    = 1'b0;
        ready_mode = RDY_ALWAYS;
        q = '{8'h82, 8'hA8, 8'h5A, 8'hC3, 8'h0F, 8'hF0};
        for (int i = 0; i < 40; i++)
            q = {q, 8'($urandom)};
        holdoff_req = 1'b1;
        send_buffer(q);
    endtask

    // One buffer: mostly a well-formed frame, sometimes cut short or padded,
    // sometimes plain noise.
    task automatic send_random_buffer();
        byte_q_t     q;
        int unsigned sel;
        int unsigned len;
        int unsigned n_payload;
        int unsigned stop;
        logic        mbit;
        sel  = $urandom_range(0, 99);
        mbit = 1'($urandom);
        if (sel < 8) begin
            repeat ($urandom_range(1, 10)) q = {q, 8'($urandom)};
        end else begin
            q = {q, 8'($urandom)};
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                len = $urandom_range(0, 20);
                q = {q, {mbit, 7'(len)}};
            end else if (sel < 68) begin
                len = $urandom_range(21, 125);
                q = {q, {mbit, 7'(len)}};
            end else if (sel < 74) begin
                len = 127;
                q = {q, {mbit, 7'd127}};
            end else begin
                len = (sel < 92) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
                q = {q, {mbit, wfu_pkg::LEN_EXTENDED}};
                q = {q, len[15:8]};
                q = {q, len[7:0]};
            end
            repeat (4) q = {q, 8'($urandom)};
            n_payload = (len > 200) ? $urandom_range(0, 30) : len;
            repeat (n_payload) q = {q, 8'($urandom)};
            sel = $urandom_range(0, 99);
            if (sel < 15 && len <= 200)
                repeat ($urandom_range(1, 4)) q = {q, 8'($urandom)};
            // cut the buffer short somewhere, header included
            if (sel >= 80 || len > 200) begin
                stop = $urandom_range(0, q.size() - 1);
                while (q.size() > stop + 1)
                    void'(q.pop_back());
            end
        end
        send_buffer(q);
    endtask

    task automatic test_random_frames();
        int unsigned n_buf;
        int unsigned start;
        n_buf = 0;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            if (n_buf % 8 == 0) begin
                gaps_on    = ($urandom_range(0, 3) != 0);
                ready_mode = ready_mode_t'($urandom_range(0, 2));
            end
            send_random_buffer();
            n_buf++;
        end
    endtask

    initial begin
        int unsigned drain;
        words_sent  = 0;
        error_count = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        ready_mode  = RDY_RANDOM;
        holdoff_req = 1'b0;
        clear_parser();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_short_buffers();
        test_zero_length();
        test_exact_length();
        test_early_end();
        test_output_holdoff();
        test_random_frames();

        s_valid <= 1'b0;
        drain = 0;
        while (expected_words.size() != 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        if (expected_words.size() != 0) begin
            $error("%0d expected results never arrived", expected_words.size());
            error_count++;
        end
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
